@@ sv/gtg_pkg.sv @@
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants for go-to-goal steering
// Holds payload structs, register indexes, fixed-point constants and the
// arctangent table used by the cordic cells.
// ----------------------------------------------------------------------------
package gtg_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanLen = 24;

   // angle accumulator: q24 with enough integer bits for +-pi plus margin
   localparam int ZW = 28;
   // cordic x/y: 17 bit offsets times 2^14, plus growth
   localparam int XYW = 34;
   localparam int DistW = 19;
   localparam int SqW = 35;

   localparam logic signed [ZW-1:0] PiQ24 = 28'sd52707179;
   localparam logic signed [17:0] PiQ13 = 18'sd25736;
   localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;

   typedef enum logic [2:0] {
      REG_GOAL_X = 3'd0,
      REG_GOAL_Y = 3'd1,
      REG_LIN_GAIN = 3'd2,
      REG_ANG_GAIN = 3'd3,
      REG_DIST_THR = 3'd4,
      REG_ANG_THR = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] pose_heading;
   } req_type;

   typedef struct packed {
      logic [15:0] linear_speed;
      logic signed [15:0] angular_speed;
      logic reached;
   } rsp_type;

   // data moved from cell to cell
   typedef struct packed {
      logic valid;
      logic signed [XYW-1:0] x;
      logic signed [XYW-1:0] y;
      logic signed [ZW-1:0] z;
      logic zero;
      logic signed [15:0] heading;
      logic [DistW-1:0] root;
      logic [SqW-1:0] sq;
   } cell_type;

   function automatic logic signed [ZW-1:0] atan_q24(input int i);
      logic signed [ZW-1:0] t;
      case (i)
         0: t = 28'sd13176795;
         1: t = 28'sd7778716;
         2: t = 28'sd4110060;
         3: t = 28'sd2086331;
         4: t = 28'sd1047214;
         5: t = 28'sd524117;
         6: t = 28'sd262123;
         7: t = 28'sd131069;
         default: t = (i < AtanLen) ? ZW'(28'sd16777216 >>> i) : '0;
      endcase
      return t;
   endfunction

endpackage

@@ sv/gtg_cell.sv @@
// ----------------------------------------------------------------------------
// gtg_cell: one cordic rotation step and, with DoRoot set, one square root bit step
// Registered; hands its item to the next cell every cycle.
// ----------------------------------------------------------------------------
module gtg_cell import gtg_pkg::*; #(
   parameter int Step = 0,
   parameter int RootBit = 0,
   parameter bit DoRoot = 1'b1
) (
   input  logic clock,
   input  logic reset,
   input  cell_type cell_i,
   output cell_type cell_o
);

   cell_type cell_ff, cell_in;
   logic signed [XYW-1:0] xs, ys;
   logic [DistW-1:0] cand;
   logic [2*DistW-1:0] trial;

   always_comb begin
      cell_in = cell_i;
      xs = cell_i.x >>> Step;
      ys = cell_i.y >>> Step;
      // rotate towards the x axis
      if (cell_i.y > 0) begin
         cell_in.x = cell_i.x + ys;
         cell_in.y = cell_i.y - xs;
         cell_in.z = cell_i.z + atan_q24(Step);
      end else begin
         cell_in.x = cell_i.x - ys;
         cell_in.y = cell_i.y + xs;
         cell_in.z = cell_i.z - atan_q24(Step);
      end
      // one bit of the integer square root, squared at full width
      cand = cell_i.root | DistW'(1 << RootBit);
      trial = '0;
      if (DoRoot) begin
         trial = (2*DistW)'(cand) * (2*DistW)'(cand);
         if (trial <= (2*DistW)'(cell_i.sq)) cell_in.root = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

@@ sv/go_to_goal_steering_top.sv @@
// ----------------------------------------------------------------------------
// go_to_goal_steering_top: proportional go-to-goal controller
// Pose in, speed command out, through a chain of cordic/root cells.
// ----------------------------------------------------------------------------
// usage:
//   raise req_start with req_data (pose x, y, heading); busy is always low,
//   so one item is taken every cycle.
//   rsp_valid strobes for one cycle with rsp_data once the item has passed
//   the entry stage, one cell per cordic step or root bit, whichever is
//   more, a wrap stage, a product stage and an output stage. The cell chain
//   length sets the latency; throughput is one item per cycle.
//   csr_we/csr_index/csr_wdata write the goal, gains and thresholds; write
//   only while no items are in flight. Unused indexes are ignored.
//   synchronous reset flushes the chain and loads the default goal and gains.
//   the receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module go_to_goal_steering_top import gtg_pkg::*; #(
   parameter int CORDIC_STEPS = CordicStepsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int Cells = (CORDIC_STEPS > DistW) ? CORDIC_STEPS : DistW;

   logic signed [15:0] goal_x_ff, goal_y_ff;
   logic [15:0] lin_gain_ff, ang_gain_ff, dist_thr_ff;
   logic [14:0] ang_thr_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= 16'sd11264;
         goal_y_ff <= 16'sd11264;
         lin_gain_ff <= 16'd2048;
         ang_gain_ff <= 16'd6144;
         dist_thr_ff <= 16'd205;
         ang_thr_ff <= 15'd819;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GOAL_X: goal_x_ff <= csr_wdata;
            REG_GOAL_Y: goal_y_ff <= csr_wdata;
            REG_LIN_GAIN: lin_gain_ff <= csr_wdata;
            REG_ANG_GAIN: ang_gain_ff <= csr_wdata;
            REG_DIST_THR: dist_thr_ff <= csr_wdata;
            REG_ANG_THR: ang_thr_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // entry stage: offsets, squares, quadrant fold
   cell_type entry_in, entry_ff;
   logic signed [16:0] dx, dy;
   always_comb begin
      dx = 17'(goal_x_ff) - 17'(req_data.pose_x);
      dy = 17'(goal_y_ff) - 17'(req_data.pose_y);
      entry_in = '0;
      entry_in.valid = req_start;
      entry_in.heading = req_data.pose_heading;
      entry_in.zero = (dx == 0) && (dy == 0);
      entry_in.x = XYW'(dx) <<< 14;
      entry_in.y = XYW'(dy) <<< 14;
      entry_in.sq = SqW'(34'(dx) * 34'(dx)) + SqW'(34'(dy) * 34'(dy));
      if (dx < 0) begin
         entry_in.x = -(XYW'(dx) <<< 14);
         entry_in.y = -(XYW'(dy) <<< 14);
         entry_in.z = (dy >= 0) ? PiQ24 : -PiQ24;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // chain of cells
   cell_type chain [Cells+1];
   assign chain[0] = entry_ff;
   for (genvar g = 0; g < Cells; g++) begin : g_cell
      gtg_cell #(
         .Step((g < CORDIC_STEPS) ? g : AtanLen),
         .RootBit((g < DistW) ? DistW - 1 - g : 0),
         .DoRoot(g < DistW)
      ) u_cell (
         .clock(clock), .reset(reset), .cell_i(chain[g]), .cell_o(chain[g+1])
      );
   end

   // error wrap and compare stage
   cell_type tail;
   logic signed [ZW-1:0] zr;
   logic signed [17:0] brg, err_w;
   logic signed [17:0] err_ff;
   logic [DistW-1:0] dist_ff;
   logic drive_ff, steer_ff, reach_ff, v1_ff;
   assign tail = chain[Cells];
   always_comb begin
      zr = (tail.z + ZW'(1024)) >>> 11;
      brg = tail.zero ? 18'sd0 : 18'(zr);
      err_w = brg - 18'(tail.heading);
      if (err_w > PiQ13) err_w = err_w - TwoPiQ13;
      if (err_w < -PiQ13) err_w = err_w + TwoPiQ13;
   end
   always_ff @(posedge clock) begin
      err_ff <= err_w;
      dist_ff <= tail.root;
      drive_ff <= tail.root >= DistW'(dist_thr_ff);
      steer_ff <= ((err_w < 0) ? -err_w : err_w) >= 18'(ang_thr_ff);
      reach_ff <= (tail.root < DistW'(dist_thr_ff)) && (tail.root != '0);
      v1_ff <= reset ? 1'b0 : tail.valid;
   end

   // product stage
   logic signed [35:0] angp_ff;
   logic [34:0] linp_ff;
   logic drive2_ff, steer2_ff, reach2_ff, v2_ff;
   always_ff @(posedge clock) begin
      angp_ff <= 36'($signed({1'b0, ang_gain_ff})) * 36'(err_ff);
      linp_ff <= 35'(lin_gain_ff) * 35'(dist_ff);
      drive2_ff <= drive_ff;
      steer2_ff <= steer_ff;
      reach2_ff <= reach_ff;
      v2_ff <= reset ? 1'b0 : v1_ff;
   end

   // rounding, saturation and output register
   logic signed [35:0] ar;
   logic [34:0] lr;
   rsp_type rsp_in, rsp_ff;
   logic rsp_valid_ff;
   always_comb begin
      ar = (angp_ff + 36'sd4096) >>> 13;
      lr = (linp_ff + 35'd1024) >> 11;
      rsp_in = '0;
      rsp_in.reached = reach2_ff;
      if (drive2_ff) begin
         rsp_in.linear_speed = (lr > 35'd65535) ? 16'hFFFF : lr[15:0];
         if (steer2_ff) begin
            if (ar > 36'sd32767) rsp_in.angular_speed = 16'sh7FFF;
            else if (ar < -36'sd32768) rsp_in.angular_speed = -16'sd32768;
            else rsp_in.angular_speed = ar[15:0];
         end
      end
   end
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      rsp_valid_ff <= reset ? 1'b0 : v2_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTH
   // arrival and drive never together
   a_reach_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reached |-> rsp_data.linear_speed == 16'd0)
      else $error("reached with nonzero speed");
   // no turn while reached
   a_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.angular_speed != 16'sd0 |-> !rsp_data.reached)
      else $error("turning while reached");
   // product stage valid follows wrap stage
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff)
      else $error("item lost in pipe");
`endif

endmodule
